FILE: rtl/midi_channel_state_receiver_defines.svh
// assertion macros for the midi channel state receiver
// used by the top level; expects clk and rst_n in the including scope
`ifndef MIDI_CHANNEL_STATE_RECEIVER_DEFINES_SVH
`define MIDI_CHANNEL_STATE_RECEIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MCSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mcsr_pkg.sv
// shared types and constants for the midi channel state receiver
// no dependencies; imported by the parser, the top level and the testbench
package mcsr_pkg;

  localparam int NRPN_ENTRIES_DEF = 512;
  localparam int CHANNELS_DEF     = 16;

  typedef enum logic [2:0] {
    OP_MIDI_BYTE   = 3'd0,
    OP_READ_PITCH  = 3'd1,
    OP_READ_ACTIVE = 3'd2,
    OP_READ_CC     = 3'd3,
    OP_READ_BEND   = 3'd4,
    OP_READ_NRPN   = 3'd5
  } opcode_t;

  // stream bytes
  localparam logic [7:0] BYTE_REALTIME  = 8'hF8;
  localparam logic [7:0] BYTE_SYSEX     = 8'hF0;
  localparam logic [7:0] NO_STATUS      = 8'h00;
  localparam logic [2:0] ONE_DATA_GROUP = 3'b110;  // program change, channel pressure

  // message kinds (upper status nibble)
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CC       = 4'hB;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  // controller numbers
  localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
  localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
  localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
  localparam logic [6:0] CC_RPN_MSB    = 7'd101;
  localparam logic [6:0] CC_RPN_LSB    = 7'd100;

  localparam logic [13:0] BEND_CENTRE = 14'd8192;
  localparam logic [6:0]  PITCH_RESET = 7'd60;

  // complete channel message from the parser
  typedef struct packed {
    logic       run;
    logic [3:0] chan;
    logic [3:0] kind;
    logic [6:0] a;
    logic [6:0] b;
  } msg_t;

endpackage

FILE: rtl/mcsr_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module mcsr_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mcsr_parser.sv
// midi byte stream parser: running status, sysex skip, data byte collection
// depends on mcsr_pkg; emits at most one complete channel message per transfer
module mcsr_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        data_byte,
  output mcsr_pkg::msg_t    msg
);
  import mcsr_pkg::*;

  logic [7:0] status_r, status_nxt;
  logic [6:0] first_r, first_nxt;
  logic       count_r, count_nxt;
  logic       sysex_r, sysex_nxt;

  always_comb begin
    status_nxt = status_r;
    first_nxt  = first_r;
    count_nxt  = count_r;
    sysex_nxt  = sysex_r;
    msg        = '0;
    msg.chan   = status_r[3:0];
    msg.kind   = status_r[7:4];
    if (byte_valid) begin
      priority if (data_byte >= BYTE_REALTIME) begin
        // real-time bytes pass through untouched
      end else if (data_byte == BYTE_SYSEX) begin
        sysex_nxt = 1'b1;
      end else if (data_byte[7]) begin
        sysex_nxt  = 1'b0;
        status_nxt = (data_byte < BYTE_SYSEX) ? data_byte : NO_STATUS;
        count_nxt  = 1'b0;
      end else if (!sysex_r && status_r != NO_STATUS) begin
        if (status_r[7:5] == ONE_DATA_GROUP) begin
          msg.run   = 1'b1;
          msg.a     = data_byte[6:0];
          count_nxt = 1'b0;
        end else if (!count_r) begin
          first_nxt = data_byte[6:0];
          count_nxt = 1'b1;
        end else begin
          msg.run   = 1'b1;
          msg.a     = first_r;
          msg.b     = data_byte[6:0];
          count_nxt = 1'b0;
        end
      end else begin
        // data byte inside sysex or with no status: skipped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= NO_STATUS;
      first_r  <= '0;
      count_r  <= 1'b0;
      sysex_r  <= 1'b0;
    end else begin
      status_r <= status_nxt;
      first_r  <= first_nxt;
      count_r  <= count_nxt;
      sysex_r  <= sysex_nxt;
    end
  end

endmodule

FILE: rtl/midi_channel_state_receiver.sv
// midi channel state receiver top level: per-channel state, cc and nrpn rams
// depends on mcsr_pkg, mcsr_parser, mcsr_ram and the assertion macro header
//
//  channel  direction  payload                                      handshake
//  in_      in         opcode, data_byte, query_channel, query_idx  in_valid / in_stall
//  out_     out        read_value (signed 14 bit)                   out_valid / out_stall
//
// one transfer per cycle on the input while in_stall is low; a read passes through the
// ram read stage, then the output register, before it appears at the output
// stream bytes update state in the cycle they are taken, so a read right behind sees them
// after reset a clearing pass over CHANNELS*max(128, NRPN_ENTRIES) addresses (8192 at
// defaults) zeroes both rams, with in_stall held high throughout
// out_stall only stalls the input once both the ram read stage and the output hold results
`include "midi_channel_state_receiver_defines.svh"

module midi_channel_state_receiver #(
  parameter int NRPN_ENTRIES = mcsr_pkg::NRPN_ENTRIES_DEF,
  parameter int CHANNELS     = mcsr_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [7:0]         in_data_byte,
  input  logic [3:0]         in_query_channel,
  input  logic [8:0]         in_query_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [13:0] out_read_value
);
  import mcsr_pkg::*;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CC_DEPTH  = CHANNELS * 128;
  localparam int CC_AW     = $clog2(CC_DEPTH);
  localparam int NR_DEPTH  = CHANNELS * NRPN_ENTRIES;
  localparam int NR_AW     = (NR_DEPTH > 1) ? $clog2(NR_DEPTH) : 1;
  localparam int CLR_DEPTH = (CC_DEPTH > NR_DEPTH) ? CC_DEPTH : NR_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  // where the read stage takes its value from
  typedef enum logic [1:0] {
    SRC_FLOP,
    SRC_CC,
    SRC_NRPN
  } src_t;

  // handshake
  logic in_accept;
  logic s1_adv;

  // clearing pass
  logic              clr_busy_r, clr_busy_nxt;
  logic [CLR_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_cc, clr_nr;

  // per-channel state in flops
  logic [6:0]  pitch_r  [CHANNELS];
  logic [6:0]  pitch_nxt[CHANNELS];
  logic        active_r [CHANNELS];
  logic        active_nxt[CHANNELS];
  logic [13:0] bend_r   [CHANNELS];
  logic [13:0] bend_nxt [CHANNELS];
  logic [6:0]  nhigh_r  [CHANNELS];
  logic [6:0]  nhigh_nxt[CHANNELS];
  logic [6:0]  nlow_r   [CHANNELS];
  logic [6:0]  nlow_nxt [CHANNELS];
  logic        armed_r  [CHANNELS];
  logic        armed_nxt[CHANNELS];

  // parser and message decode
  msg_t        msg;
  logic        msg_ok;
  logic [CH_W-1:0] mch;
  logic [13:0] nr_index;
  logic        cc_msg_we, nr_msg_we;

  // ram ports
  logic             cc_we, cc_re;
  logic [CC_AW-1:0] cc_waddr, cc_raddr;
  logic [6:0]       cc_wdata, cc_rdata;
  logic             nr_we, nr_re;
  logic [NR_AW-1:0] nr_waddr, nr_raddr;
  logic [6:0]       nr_wdata, nr_rdata;

  // read decode
  logic            q_ok, q_read;
  logic [CH_W-1:0] qch;
  logic [13:0]     q_value;
  src_t            q_src;

  // read stage and output register
  logic        s1_valid_r, s1_valid_nxt;
  src_t        s1_src_r, s1_src_nxt;
  logic [13:0] s1_value_r, s1_value_nxt;
  logic [13:0] s1_result;
  logic        out_valid_r, out_valid_nxt;
  logic [13:0] out_value_r, out_value_nxt;

  // input stalls during the clearing pass or when both result slots are full and the output is stalled
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = clr_busy_r || (s1_valid_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  mcsr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_accept && (opcode_t'(in_opcode) == OP_MIDI_BYTE)),
    .data_byte  (in_data_byte),
    .msg        (msg)
  );

  // clearing pass sequencing
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == CLR_AW'(CLR_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  assign clr_cc = clr_busy_r && (int'(clr_cnt_r) < CC_DEPTH);
  assign clr_nr = clr_busy_r && (int'(clr_cnt_r) < NR_DEPTH);

  // message side: channel state update and ram writes
  assign mch       = CH_W'(msg.chan);
  assign msg_ok    = msg.run && (5'(msg.chan) < 5'(CHANNELS));
  assign nr_index  = {nhigh_r[mch], nlow_r[mch]};
  assign cc_msg_we = msg_ok && (msg.kind == KIND_CC);
  assign nr_msg_we = cc_msg_we && (msg.a == CC_DATA_ENTRY) && armed_r[mch]
                     && (15'(nr_index) < 15'(NRPN_ENTRIES));

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      pitch_nxt[c]  = pitch_r[c];
      active_nxt[c] = active_r[c];
      bend_nxt[c]   = bend_r[c];
      nhigh_nxt[c]  = nhigh_r[c];
      nlow_nxt[c]   = nlow_r[c];
      armed_nxt[c]  = armed_r[c];
    end
    if (msg_ok) begin
      priority if (msg.kind == KIND_NOTE_ON && msg.b != 7'd0) begin
        pitch_nxt[mch]  = msg.a;
        active_nxt[mch] = 1'b1;
      end else if (msg.kind == KIND_NOTE_ON || msg.kind == KIND_NOTE_OFF) begin
        // release only when the key matches the sounding one
        if (msg.a == pitch_r[mch]) begin
          active_nxt[mch] = 1'b0;
        end
      end else if (msg.kind == KIND_CC) begin
        priority if (msg.a == CC_NRPN_MSB) begin
          nhigh_nxt[mch] = msg.b;
          armed_nxt[mch] = 1'b1;
        end else if (msg.a == CC_NRPN_LSB) begin
          nlow_nxt[mch]  = msg.b;
          armed_nxt[mch] = 1'b1;
        end else if (msg.a == CC_RPN_MSB || msg.a == CC_RPN_LSB) begin
          armed_nxt[mch] = 1'b0;
        end else begin
          // other controllers, data entry included, are kept only in the rams
        end
      end else if (msg.kind == KIND_BEND) begin
        bend_nxt[mch] = {msg.b, msg.a} - BEND_CENTRE;
      end else begin
        // poly pressure, program change, channel pressure: nothing kept
      end
    end
  end

  // ram write ports: the clearing pass owns them until it is done
  assign cc_we    = clr_cc || cc_msg_we;
  assign cc_waddr = clr_busy_r ? CC_AW'(clr_cnt_r) : CC_AW'({msg.chan, msg.a});
  assign cc_wdata = clr_busy_r ? 7'd0 : msg.b;

  assign nr_we    = clr_nr || nr_msg_we;
  assign nr_waddr = clr_busy_r ? NR_AW'(clr_cnt_r)
                  : NR_AW'(msg.chan) * NR_AW'(NRPN_ENTRIES) + NR_AW'(nr_index);
  assign nr_wdata = clr_busy_r ? 7'd0 : msg.b;

  mcsr_ram #(
    .WIDTH (7),
    .DEPTH (CC_DEPTH)
  ) u_cc_ram (
    .clk   (clk),
    .we    (cc_we),
    .waddr (cc_waddr),
    .wdata (cc_wdata),
    .re    (cc_re),
    .raddr (cc_raddr),
    .rdata (cc_rdata)
  );

  mcsr_ram #(
    .WIDTH (7),
    .DEPTH (NR_DEPTH)
  ) u_nrpn_ram (
    .clk   (clk),
    .we    (nr_we),
    .waddr (nr_waddr),
    .wdata (nr_wdata),
    .re    (nr_re),
    .raddr (nr_raddr),
    .rdata (nr_rdata)
  );

  // query side: flop values picked now, ram values come from the registered ram read port
  assign qch      = CH_W'(in_query_channel);
  assign q_ok     = 5'(in_query_channel) < 5'(CHANNELS);
  assign cc_raddr = CC_AW'({in_query_channel, in_query_index[6:0]});
  assign nr_raddr = NR_AW'(in_query_channel) * NR_AW'(NRPN_ENTRIES)
                    + NR_AW'(in_query_index);

  always_comb begin
    q_read  = 1'b0;
    q_value = '0;
    q_src   = SRC_FLOP;
    cc_re   = 1'b0;
    nr_re   = 1'b0;
    unique case (opcode_t'(in_opcode))
      OP_READ_PITCH: begin
        q_read = 1'b1;
        if (q_ok) q_value = {7'd0, pitch_r[qch]};
      end
      OP_READ_ACTIVE: begin
        q_read = 1'b1;
        if (q_ok) q_value = {13'd0, active_r[qch]};
      end
      OP_READ_BEND: begin
        q_read = 1'b1;
        if (q_ok) q_value = bend_r[qch];
      end
      OP_READ_CC: begin
        q_read = 1'b1;
        if (q_ok && !in_query_index[8] && !in_query_index[7]) begin
          q_src = SRC_CC;
          cc_re = in_accept;
        end
      end
      OP_READ_NRPN: begin
        q_read = 1'b1;
        if (q_ok && (15'(in_query_index) < 15'(NRPN_ENTRIES))) begin
          q_src = SRC_NRPN;
          nr_re = in_accept;
        end
      end
      default: begin
        // stream byte or unused opcode: no result
      end
    endcase
  end

  always_comb begin
    unique case (s1_src_r)
      SRC_CC:   s1_result = {7'd0, cc_rdata};
      SRC_NRPN: s1_result = {7'd0, nr_rdata};
      default:  s1_result = s1_value_r;
    endcase
  end

  // read stage holds while the output register is full and stalled
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_src_nxt    = s1_src_r;
    s1_value_nxt  = s1_value_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) out_value_nxt = s1_result;
      s1_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      s1_valid_nxt = q_read;
      s1_src_nxt   = q_src;
      s1_value_nxt = q_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pitch_r[c]  <= PITCH_RESET;
        active_r[c] <= 1'b0;
        bend_r[c]   <= '0;
        nhigh_r[c]  <= '0;
        nlow_r[c]   <= '0;
        armed_r[c]  <= 1'b0;
      end
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        pitch_r[c]  <= pitch_nxt[c];
        active_r[c] <= active_nxt[c];
        bend_r[c]   <= bend_nxt[c];
        nhigh_r[c]  <= nhigh_nxt[c];
        nlow_r[c]   <= nlow_nxt[c];
        armed_r[c]  <= armed_nxt[c];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_src_r    <= s1_src_nxt;
    s1_value_r  <= s1_value_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;

  // checks on the internal pipeline and the clearing pass
  `MCSR_ASSERT_NOW(a_no_transfer_in_clear, clr_busy_r, in_stall, "transfer during clear")
  `MCSR_ASSERT_NOW(a_no_msg_in_clear, msg.run, !clr_busy_r, "message while clearing")
  `MCSR_ASSERT_NEXT(a_read_enters_stage, in_accept && q_read, s1_valid_r, "read lost")
  `MCSR_ASSERT_NOW(a_stage_hold_needs_out, s1_valid_r && !s1_adv, out_valid_r,
                   "read stage held with empty output")

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the midi channel state receiver
// depends on mcsr_pkg and the midi_channel_state_receiver rtl; stands alone otherwise
// directed table first, then shaped random midi traffic checked against a behavioural predictor
module tb_top;
  import mcsr_pkg::*;

  localparam int NUM_CHANNELS     = CHANNELS_DEF;
  localparam int NRPN_DEPTH       = NRPN_ENTRIES_DEF;
  localparam int CLK_HALF         = 6;
  localparam int RUN_LIMIT_CYCLES = 300000;
  localparam int PHASE_ITEMS      = 210;
  localparam int DRAIN_CYCLES     = 16;
  localparam int NUM_ROWS         = 26;

  // opcodes the block must swallow without a result
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // stream bytes used only by the stimulus
  localparam logic [7:0] BYTE_EOX        = 8'hF7;
  localparam logic [7:0] BYTE_COMMON_MIN = 8'hF1;
  localparam logic [7:0] BYTE_STATUS_MIN = 8'h80;

  // idle and stall mix per phase: heavy receiver stalls, then heavy sender idles, then flat out
  localparam int SEND_IDLE_PCT [3] = '{25, 83, 0};
  localparam int RECV_STALL_PCT[3] = '{83, 25, 0};

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [3:0]  chan;
    logic [8:0]  index;
    logic        typed;
    logic [13:0] value;
  } directed_row_t;

  // directed table: reset values, bend extremes, note on at the top key, nrpn entry,
  // real-time byte inside a message, cc read out of range, spare opcodes
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{OP_READ_PITCH,  8'h00,                   4'd0,  9'd0,   1'b1, 14'd60},
    '{OP_READ_ACTIVE, 8'hFF,                   4'd15, 9'd511, 1'b1, 14'd0},
    '{OP_READ_NRPN,   8'h00,                   4'd15, 9'd511, 1'b1, 14'd0},
    '{OP_SPARE_6,     8'hFF,                   4'd15, 9'd511, 1'b0, 14'd0},
    '{OP_MIDI_BYTE,   {KIND_BEND, 4'd5},       4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   8'h7F,                   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   8'h7F,                   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_READ_BEND,   8'h00,                   4'd5,  9'd0,   1'b1, 14'h1FFF},
    '{OP_MIDI_BYTE,   8'h00,                   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   BYTE_REALTIME,           4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   8'h00,                   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_READ_BEND,   8'h00,                   4'd5,  9'd0,   1'b1, 14'h2000},
    '{OP_MIDI_BYTE,   {KIND_NOTE_ON, 4'd15},   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   8'h7F,                   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   8'h7F,                   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_READ_PITCH,  8'h00,                   4'd15, 9'd0,   1'b1, 14'd127},
    '{OP_READ_ACTIVE, 8'h00,                   4'd15, 9'd0,   1'b1, 14'd1},
    '{OP_MIDI_BYTE,   {KIND_CC, 4'd2},         4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   {1'b0, CC_NRPN_MSB},     4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   8'h00,                   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   {1'b0, CC_DATA_ENTRY},   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_MIDI_BYTE,   8'h7F,                   4'd0,  9'd0,   1'b0, 14'd0},
    '{OP_READ_NRPN,   8'h00,                   4'd2,  9'd0,   1'b0, 14'd0},
    '{OP_READ_CC,     8'h00,                   4'd2,  9'd6,   1'b0, 14'd0},
    '{OP_READ_CC,     8'h00,                   4'd2,  9'h1FF, 1'b1, 14'd0},
    '{OP_SPARE_7,     8'h00,                   4'd0,  9'd0,   1'b0, 14'd0}
  };

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic [2:0]         in_opcode        = OP_MIDI_BYTE;
  logic [7:0]         in_data_byte     = 8'h00;
  logic [3:0]         in_query_channel = 4'd0;
  logic [8:0]         in_query_index   = 9'd0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic signed [13:0] out_read_value;

  // predictor copy of the parser and the per-channel state
  logic [7:0]  stream_status;
  logic [6:0]  held_first;
  bit          have_first;
  bit          sysex_open;
  logic [6:0]  note_key    [NUM_CHANNELS];
  bit          note_on     [NUM_CHANNELS];
  logic [13:0] bend_now    [NUM_CHANNELS];
  logic [6:0]  cc_table    [NUM_CHANNELS][128];
  logic [6:0]  nrpn_table  [NUM_CHANNELS][NRPN_DEPTH];
  logic [6:0]  nrpn_sel_hi [NUM_CHANNELS];
  logic [6:0]  nrpn_sel_lo [NUM_CHANNELS];
  bit          nrpn_live   [NUM_CHANNELS];

  // reads awaiting their result, oldest first
  logic [13:0] expected_reads[$];
  logic [13:0] head_read;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int checked_count  = 0;
  int byte_count     = 0;
  int read_count     = 0;
  int nrpn_entries   = 0;
  int useful_count   = 0;

  // steer random reads towards state that has just been written
  logic [3:0] focus_chan = 4'd0;
  logic [6:0] focus_cc   = 7'd0;
  logic [8:0] focus_nrpn = 9'd0;

  midi_channel_state_receiver #(
    .NRPN_ENTRIES(NRPN_DEPTH),
    .CHANNELS    (NUM_CHANNELS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .in_query_channel(in_query_channel),
    .in_query_index  (in_query_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // a complete channel message as it lands on the channel state
  function automatic void apply_channel_message(logic [7:0] status, logic [6:0] a,
                                                logic [6:0] b);
    logic [3:0]  ch;
    logic [3:0]  kind;
    logic [13:0] sel;
    ch   = status[3:0];
    kind = status[7:4];
    if (ch >= NUM_CHANNELS) return;
    if (kind == KIND_NOTE_ON && b != 7'd0) begin
      note_key[ch] = a;
      note_on[ch]  = 1'b1;
    end else if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
      // release only counts when it names the held key
      if (a == note_key[ch]) note_on[ch] = 1'b0;
    end else if (kind == KIND_CC) begin
      cc_table[ch][a] = b;
      if (a == CC_NRPN_MSB) begin
        nrpn_sel_hi[ch] = b;
        nrpn_live[ch]   = 1'b1;
      end else if (a == CC_NRPN_LSB) begin
        nrpn_sel_lo[ch] = b;
        nrpn_live[ch]   = 1'b1;
      end else if (a == CC_RPN_MSB || a == CC_RPN_LSB) begin
        nrpn_live[ch] = 1'b0;
      end else if (a == CC_DATA_ENTRY && nrpn_live[ch]) begin
        sel = {nrpn_sel_hi[ch], nrpn_sel_lo[ch]};
        nrpn_entries++;
        // selections past the table are dropped
        if (sel < NRPN_DEPTH) nrpn_table[ch][sel] = b;
      end
    end else if (kind == KIND_BEND) begin
      bend_now[ch] = {b, a} - BEND_CENTRE;
    end
  endfunction

  // parser step; returns 0 when the byte is merely skipped
  function automatic bit track_stream_byte(logic [7:0] v);
    bit took;
    took = 1'b1;
    if (v >= BYTE_REALTIME) begin
      took = 1'b0;
    end else if (v == BYTE_SYSEX) begin
      sysex_open = 1'b1;
    end else if (v[7]) begin
      // system common drops running status
      sysex_open    = 1'b0;
      stream_status = (v < BYTE_SYSEX) ? v : NO_STATUS;
      have_first    = 1'b0;
    end else if (sysex_open || stream_status == NO_STATUS) begin
      took = 1'b0;
    end else if (stream_status[7:5] == ONE_DATA_GROUP) begin
      apply_channel_message(stream_status, v[6:0], 7'd0);
      have_first = 1'b0;
    end else if (!have_first) begin
      held_first = v[6:0];
      have_first = 1'b1;
    end else begin
      apply_channel_message(stream_status, held_first, v[6:0]);
      have_first = 1'b0;
    end
    return took;
  endfunction

  function automatic logic [13:0] lookup_channel_state(logic [2:0] op, logic [3:0] ch,
                                                       logic [8:0] idx);
    logic [13:0] v;
    v = 14'd0;
    if (ch < NUM_CHANNELS) begin
      case (op)
        OP_READ_PITCH:  v = {7'd0, note_key[ch]};
        OP_READ_ACTIVE: v = {13'd0, note_on[ch]};
        OP_READ_CC:     if (idx < 128) v = {7'd0, cc_table[ch][idx[6:0]]};
        OP_READ_BEND:   v = bend_now[ch];
        OP_READ_NRPN:   if (idx < NRPN_DEPTH) v = {7'd0, nrpn_table[ch][idx]};
        default:        v = 14'd0;
      endcase
    end
    return v;
  endfunction

  // one input transfer; the sender may idle first, the payload holds while stalled
  task automatic send_item(input logic [2:0] op, input logic [7:0] b, input logic [3:0] ch,
                           input logic [8:0] idx, input bit use_typed = 1'b0,
                           input logic [13:0] typed_val = 14'd0);
    logic [13:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_data_byte     <= b;
    in_query_channel <= ch;
    in_query_index   <= idx;
    do @(posedge clk); while (in_stall);
    // transfer taken at this edge
    if (op == OP_MIDI_BYTE) begin
      byte_count++;
      if (track_stream_byte(b)) useful_count++;
    end else if (op >= OP_READ_PITCH && op <= OP_READ_NRPN) begin
      predicted = lookup_channel_state(op, ch, idx);
      expected_reads.push_back(use_typed ? typed_val : predicted);
      read_count++;
      useful_count++;
    end
  endtask

  // stream byte with junk in the query fields
  task automatic send_byte(input logic [7:0] v);
    send_item(OP_MIDI_BYTE, v, 4'($urandom_range(15)), 9'($urandom_range(511)));
  endtask

  // one burst of random traffic: mostly well-formed messages and reads, some noise
  task automatic send_random_traffic();
    int         pick;
    int         sub;
    int         n;
    logic [7:0] status;
    logic [3:0] ch;
    logic [2:0] op;
    logic [8:0] idx;
    logic [6:0] a;
    logic [6:0] b;
    logic [6:0] hi;
    logic [6:0] lo;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // channel message, sometimes riding on running status
      if (stream_status[7] && stream_status < BYTE_SYSEX && $urandom_range(99) < 30) begin
        status = stream_status;
      end else begin
        status = {1'b1, 3'($urandom_range(6)), 4'($urandom_range(15))};
        send_byte(status);
      end
      ch         = status[3:0];
      focus_chan = ch;
      if (status[7:4] == KIND_NOTE_ON || status[7:4] == KIND_NOTE_OFF) begin
        a = ($urandom_range(2) == 0) ? note_key[ch] : 7'($urandom_range(127));
      end else if (status[7:4] == KIND_CC) begin
        sub = $urandom_range(9);
        case (sub)
          0:       a = CC_DATA_ENTRY;
          1:       a = CC_NRPN_MSB;
          2:       a = CC_NRPN_LSB;
          3:       a = CC_RPN_MSB;
          4:       a = CC_RPN_LSB;
          default: a = 7'($urandom_range(127));
        endcase
        focus_cc = a;
      end else begin
        a = 7'($urandom_range(127));
      end
      sub = $urandom_range(7);
      b   = (sub == 0) ? 7'd0 : (sub == 1) ? 7'h7F : 7'($urandom_range(127));
      send_byte({1'b0, a});
      // real-time bytes may cut into a message
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255, 248)));
      if (status[7:5] != ONE_DATA_GROUP) send_byte({1'b0, b});
    end else if (pick < 50) begin
      // nrpn select and data entry; high part kept small so most land in the table
      ch = ($urandom_range(1) == 0) ? focus_chan : 4'($urandom_range(15));
      hi = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(3));
      lo = 7'($urandom_range(127));
      send_byte({KIND_CC, ch});
      send_byte({1'b0, CC_NRPN_MSB});
      send_byte({1'b0, hi});
      send_byte({1'b0, CC_NRPN_LSB});
      send_byte({1'b0, lo});
      if ($urandom_range(4) == 0) begin
        send_byte({1'b0, ($urandom_range(1) == 0) ? CC_RPN_MSB : CC_RPN_LSB});
        send_byte(8'($urandom_range(127)));
      end
      send_byte({1'b0, CC_DATA_ENTRY});
      send_byte(8'($urandom_range(127)));
      focus_chan = ch;
      focus_nrpn = {hi[1:0], lo};
    end else if (pick < 85) begin
      op = 3'($urandom_range(5, 1));
      ch = ($urandom_range(9) < 7) ? focus_chan : 4'($urandom_range(15));
      if (op == OP_READ_CC)
        idx = ($urandom_range(9) < 6) ? {2'b00, focus_cc} : 9'($urandom_range(511));
      else if (op == OP_READ_NRPN)
        idx = ($urandom_range(9) < 6) ? focus_nrpn : 9'($urandom_range(511));
      else
        idx = 9'($urandom_range(511));
      send_item(op, 8'($urandom_range(255)), ch, idx);
    end else begin
      sub = $urandom_range(3);
      case (sub)
        0: begin
          // sysex block, closed by end-of-exclusive or any status
          send_byte(BYTE_SYSEX);
          n = $urandom_range(4);
          repeat (n) send_byte(8'($urandom_range(127)));
          send_byte(($urandom_range(1) == 0) ? BYTE_EOX
                                             : 8'($urandom_range(BYTE_EOX, BYTE_STATUS_MIN)));
        end
        1:       send_byte(8'($urandom_range(BYTE_EOX, BYTE_COMMON_MIN)));
        2:       send_byte(8'($urandom_range(255)));
        default: send_item(($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7,
                           8'($urandom_range(255)), 4'($urandom_range(15)),
                           9'($urandom_range(511)));
      endcase
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result checker: every result transfer against the oldest outstanding read
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reads.size() == 0) begin
        $display("%0t: result with no read outstanding: expected none, actual %0d",
                 $time, out_read_value);
        mismatch_count++;
      end else begin
        head_read = expected_reads.pop_front();
        checked_count++;
        if (out_read_value !== head_read) begin
          $display("%0t: read_value mismatch: expected %0d, actual %0d",
                   $time, $signed(head_read), out_read_value);
          mismatch_count++;
        end
      end
    end
  end

  // hard stop; covers the ram clearing pass after reset many times over
  initial begin
    #(RUN_LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int phase;
    int target;
    // predictor reset state
    stream_status = NO_STATUS;
    held_first    = 7'd0;
    have_first    = 1'b0;
    sysex_open    = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      note_key[c]    = PITCH_RESET;
      note_on[c]     = 1'b0;
      bend_now[c]    = 14'd0;
      nrpn_sel_hi[c] = 7'd0;
      nrpn_sel_lo[c] = 7'd0;
      nrpn_live[c]   = 1'b0;
      for (int k = 0; k < 128; k++) cc_table[c][k] = 7'd0;
      for (int k = 0; k < NRPN_DEPTH; k++) nrpn_table[c][k] = 7'd0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = SEND_IDLE_PCT[phase];
      recv_stall_pct = RECV_STALL_PCT[phase];
      if (phase == 0) begin
        for (int r = 0; r < NUM_ROWS; r++)
          send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].chan,
                    DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].value);
      end
      target = useful_count + PHASE_ITEMS;
      while (useful_count < target) send_random_traffic();
    end
    in_valid <= 1'b0;

    // drain outstanding reads, then give any stray result time to show
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d stream bytes and %0d state reads, %0d results checked",
             byte_count, read_count, checked_count);
    $display("nrpn data entries driven: %0d, three sender/receiver idle mixes, %0d mismatches",
             nrpn_entries, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
